// ----- rtl/tmwf_pkg.sv -----
// Shared types and constants for the trimmed mean window filter.
// Used by tmwf_cell, tmwf_div and the top level; depends on nothing.
package tmwf_pkg;

    localparam int WINDOW   = 10;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int MAG_W    = SUM_W;
    localparam int DIV      = WINDOW - 2;
    localparam int SHIFT    = MAG_W;
    localparam int RECIP_W  = SHIFT + 1;
    localparam int PROD_W   = MAG_W + RECIP_W;

    // floor(2^SHIFT / DIV); the product with it undershoots the true
    // quotient by at most one.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIV);
    localparam logic [MAG_W-1:0]   DIV_M = MAG_W'(DIV);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [WINDOW-1:0] window_t;
    typedef sample_t [WINDOW-2:0] hist_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic signed [SAMPLE_W-1:0] mx;
        logic signed [SAMPLE_W-1:0] mn;
    } acc_t;

endpackage

// ----- rtl/tmwf_cell.sv -----
// One cell of the window chain: folds the lowest window entry into the
// running sum, maximum and minimum and passes the rest on. Uses tmwf_pkg.
module tmwf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_vld,
    input  tmwf_pkg::acc_t    in_acc,
    input  tmwf_pkg::window_t in_win,
    output logic              out_vld,
    output tmwf_pkg::acc_t    out_acc,
    output tmwf_pkg::window_t out_win
);

    logic                                 vld_reg;
    tmwf_pkg::acc_t                       acc_reg;
    tmwf_pkg::acc_t                       acc_next;
    tmwf_pkg::window_t                    win_reg;
    tmwf_pkg::window_t                    win_next;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] elem;

    assign elem = $signed(in_win[0]);

    always_comb
    begin
        acc_next.sum = in_acc.sum + tmwf_pkg::SUM_W'(elem);
        acc_next.mx  = (elem > in_acc.mx) ? elem : in_acc.mx;
        acc_next.mn  = (elem < in_acc.mn) ? elem : in_acc.mn;
        win_next     = tmwf_pkg::window_t'(in_win >> tmwf_pkg::SAMPLE_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg <= acc_next;
            win_reg <= win_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_acc = acc_reg;
    assign out_win = win_reg;

endmodule

// ----- rtl/tmwf_div.sv -----
// Trim and divide pipeline: removes max and min from the sum, then divides
// by the constant WINDOW-2 through a reciprocal multiply. Uses tmwf_pkg.
module tmwf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_vld,
    input  tmwf_pkg::acc_t               in_acc,
    output logic                         out_vld,
    output logic [tmwf_pkg::SAMPLE_W-1:0] filtered
);

    logic [3:0] vld_reg;

    logic signed [tmwf_pkg::SUM_W-1:0] trimmed;
    logic [tmwf_pkg::MAG_W-1:0]        mag1_next;
    logic [tmwf_pkg::PROD_W-1:0]       prod;
    logic [tmwf_pkg::MAG_W-1:0]        rem;
    logic [tmwf_pkg::MAG_W-1:0]        quot;
    logic [tmwf_pkg::SAMPLE_W-1:0]     filt_next;

    logic                        neg1_reg, neg2_reg, neg3_reg;
    logic [tmwf_pkg::MAG_W-1:0]  mag1_reg, mag2_reg, mag3_reg;
    logic [tmwf_pkg::MAG_W-1:0]  q0_2_reg, q0_3_reg;
    logic [tmwf_pkg::MAG_W-1:0]  p2_reg;
    logic [tmwf_pkg::SAMPLE_W-1:0] filt_reg;

    always_comb
    begin
        trimmed   = in_acc.sum - tmwf_pkg::SUM_W'(in_acc.mx) - tmwf_pkg::SUM_W'(in_acc.mn);
        mag1_next = trimmed[tmwf_pkg::SUM_W-1] ? tmwf_pkg::MAG_W'(-trimmed)
                                               : tmwf_pkg::MAG_W'(trimmed);
        prod      = tmwf_pkg::PROD_W'(mag1_reg) * tmwf_pkg::PROD_W'(tmwf_pkg::RECIP);
        rem       = mag3_reg - p2_reg;
        // The estimate is low by at most one, so a single correction suffices.
        quot      = (rem >= tmwf_pkg::DIV_M) ? q0_3_reg + 1'b1 : q0_3_reg;
        filt_next = neg3_reg ? tmwf_pkg::SAMPLE_W'(-quot) : tmwf_pkg::SAMPLE_W'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg1_reg <= trimmed[tmwf_pkg::SUM_W-1];
            mag1_reg <= mag1_next;
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            q0_2_reg <= prod[tmwf_pkg::SHIFT+tmwf_pkg::MAG_W-1:tmwf_pkg::SHIFT];
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            q0_3_reg <= q0_2_reg;
            p2_reg   <= tmwf_pkg::MAG_W'(q0_2_reg * tmwf_pkg::DIV_M);
            filt_reg <= filt_next;
        end
    end

    assign out_vld  = vld_reg[3];
    assign filtered = filt_reg;

endmodule

// ----- rtl/trimmed_mean_window_filter.sv -----
// Trimmed mean window filter: mean of the last WINDOW samples without one
// maximum and one minimum, truncated toward zero. Uses tmwf_pkg, tmwf_cell, tmwf_div.
// Throughput is one transfer per cycle while the output is not stalled; the pipeline
// has one register stage per chain cell, then the trim stage, the reciprocal multiply,
// the back multiply and the correction stage. A stalled output freezes the whole pipeline.
// Reset clears the sample history to zero and empties the pipeline.
module trimmed_mean_window_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [tmwf_pkg::SAMPLE_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [tmwf_pkg::SAMPLE_W-1:0] filtered
);

    logic              advance;
    logic              accept;
    tmwf_pkg::hist_t   hist_reg;
    tmwf_pkg::hist_t   hist_next;
    tmwf_pkg::acc_t    acc_init;
    logic [tmwf_pkg::SAMPLE_W-1:0] filt_u;

    logic              cell_vld [0:tmwf_pkg::WINDOW];
    tmwf_pkg::acc_t    cell_acc [0:tmwf_pkg::WINDOW];
    tmwf_pkg::window_t cell_win [0:tmwf_pkg::WINDOW];

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // The newest sample sits at the bottom; the oldest falls off the top.
    assign hist_next = tmwf_pkg::hist_t'({hist_reg, sample});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
        end
    end

    always_comb
    begin
        acc_init.sum = '0;
        acc_init.mx  = tmwf_pkg::SAMPLE_MIN;
        acc_init.mn  = tmwf_pkg::SAMPLE_MAX;
    end

    assign cell_vld[0] = accept;
    assign cell_acc[0] = acc_init;
    assign cell_win[0] = tmwf_pkg::window_t'({hist_reg, sample});

    for (genvar g = 0; g < tmwf_pkg::WINDOW; g++)
    begin : g_cell
        tmwf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .in_vld  (cell_vld[g]),
            .in_acc  (cell_acc[g]),
            .in_win  (cell_win[g]),
            .out_vld (cell_vld[g+1]),
            .out_acc (cell_acc[g+1]),
            .out_win (cell_win[g+1])
        );
    end

    tmwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_vld   (cell_vld[tmwf_pkg::WINDOW]),
        .in_acc   (cell_acc[tmwf_pkg::WINDOW]),
        .out_vld  (out_valid),
        .filtered (filt_u)
    );

    assign filtered = $signed(filt_u);

    a_first_cell_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cell_vld[1])
        else $error("accepted transfer did not enter the first cell");

    a_hist_takes_sample: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hist_reg[0] == $past(sample)))
        else $error("history did not take the accepted sample");

    a_hist_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(hist_reg))
        else $error("history moved without a transfer");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (cell_vld[tmwf_pkg::WINDOW] == $past(cell_vld[tmwf_pkg::WINDOW])))
        else $error("chain moved while the output was stalled");

endmodule

// ----- test/tmwf_checker.sv -----
// Checker for the trimmed mean window filter: watches both channels, predicts each
// filtered value from its own copy of the sample history and compares in order.
// Depends on tmwf_pkg for the window length and sample width.
module tmwf_checker
    import tmwf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] filtered,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Previous samples, newest first; zero after reset like the block's own store.
    logic signed [SAMPLE_W-1:0] past [WINDOW-1];
    logic signed [SAMPLE_W-1:0] expected_means [$];
    logic signed [SAMPLE_W-1:0] want;

    function automatic logic signed [SAMPLE_W-1:0] trimmed_mean(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint total;
        longint hi;
        longint lo;
        total = x;
        hi    = x;
        lo    = x;
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            if (past[k] > hi)
                hi = past[k];
            if (past[k] < lo)
                lo = past[k];
            total += past[k];
        end
        // Integer division truncates toward zero, which is what the filter does.
        return SAMPLE_W'((total - hi - lo) / longint'(WINDOW - 2));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (past[k])
                past[k] = '0;
            expected_means.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // The block registers its result, so the output side is
            // checked before this edge's input transfer is predicted.
            if (out_valid && !out_stall)
            begin
                if (expected_means.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tmwf_checker: unexpected result %0d at %0t",
                                 filtered, $realtime);
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (filtered !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("tmwf_checker: filtered mismatch at %0t: expected %0d, got %0d",
                                     $realtime, want, filtered);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_means.push_back(trimmed_mean(sample));
                for (int k = WINDOW - 2; k > 0; k--)
                    past[k] = past[k-1];
                past[0] = sample;
            end
            pending = expected_means.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Top of the trimmed mean window filter testbench: clock, reset, sample stimulus and
// output stalls, watchdog and verdict. Depends on tmwf_pkg, the block and tmwf_checker.
module tb;
    import tmwf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 1350;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_EVERY = 450;
    localparam int STALL_LIMIT = 1000;

    typedef enum int {
        MODE_UNIFORM,
        MODE_EXTREME,
        MODE_NEAR_ZERO,
        MODE_CONSTANT,
        MODE_TIES
    } pattern_e;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] filtered;

    int   fail_count;
    int   pending;
    logic in_fire = 1'b0;
    logic idle_on = 1'b1;
    int   quiet_cycles = 0;

    always #5 clk = ~clk;

    trimmed_mean_window_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .filtered (filtered)
    );

    tmwf_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Records input transfers for the driver and ends a run that has stopped moving.
    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(4) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
        if (idle_on && $urandom_range(3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = value;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic signed [SAMPLE_W-1:0] directed [$];
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] held;
        pattern_e                   pattern;
        int                         run_len;
        int                         sent;

        in_valid = 1'b0;
        sample   = '0;
        rst_n    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Zero first makes the whole window equal while the cleared history is still in
        // it; then extremes, ties at both ends and small negative windows that must
        // truncate toward zero.
        directed = '{16'sd0, 16'sd5, -16'sd7, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                     SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                     -16'sd1, 16'sd1, -16'sd3, 16'sd21845, -16'sd21846, SAMPLE_MAX,
                     SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 16'sd100, 16'sd100,
                     -16'sd100, -16'sd101, -16'sd2};
        foreach (directed[i])
            push_sample(directed[i]);
        sent = directed.size();
        wait_drained();

        while (sent < TOTAL_ITEMS)
        begin
            idle_on = (TOTAL_ITEMS - sent > CALM_TAIL) && ($urandom_range(3) != 0);
            pattern = pattern_e'($urandom_range(MODE_TIES));
            run_len = (pattern == MODE_CONSTANT) ? $urandom_range(WINDOW, 2 * WINDOW)
                                                 : $urandom_range(1, 24);
            held = SAMPLE_W'($urandom());
            for (int i = 0; i < run_len; i++)
            begin
                case (pattern)
                    MODE_UNIFORM:   value = SAMPLE_W'($urandom());
                    MODE_EXTREME:
                        case ($urandom_range(4))
                            0:       value = SAMPLE_MIN;
                            1:       value = SAMPLE_MAX;
                            2:       value = '0;
                            3:       value = -16'sd1;
                            default: value = 16'sd1;
                        endcase
                    MODE_NEAR_ZERO: value = SAMPLE_W'(int'($urandom_range(40)) - 20);
                    MODE_CONSTANT:  value = held;
                    default:        value = $urandom_range(1) ? held : SAMPLE_W'($urandom());
                endcase
                push_sample(value);
                sent++;
                if (sent % DRAIN_EVERY == 0)
                    wait_drained();
            end
        end

        in_valid = 1'b0;
        idle_on  = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (WINDOW + 8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
